// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while reset is released.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hw/rtl/cfa_pkg.sv =====
// Shared codes of the contiguous region allocator.
package cfa_pkg;

	localparam int unsigned OWNER_W = 16;

	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} policy_t;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_NOT_CONFIGURED = 3'd1,
		ST_BAD_SIZE       = 3'd2,
		ST_NO_FIT         = 3'd3,
		ST_NOT_ALLOCATED  = 3'd4,
		ST_TABLE_FULL     = 3'd5,
		ST_ALREADY        = 3'd6,
		ST_DONE           = 3'd7
	} status_t;

endpackage

// ===== hw/rtl/contiguous_fit_allocator_top.sv =====
// Top level of the contiguous region allocator with fit policies and coalescing.
// Initialize, clear and rejected requests go straight to the response. An allocate reads
// one entry a cycle: a first or next fit stops at the first fitting entry, a best or worst
// fit reads every entry; next fit first reduces its start position modulo entry_count.
// A split moves the entries above the pick up by one; a free searches for the owner, and a
// merge moves the entries above it down. Reset clears control state.
`include "assert_macros.svh"

module contiguous_fit_allocator_top #(
	parameter int unsigned MEM_SIZE    = 1024,
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [10:0] request_size,
	input  logic [15:0] owner_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] assigned_owner,
	output logic [9:0]  region_base,
	output logic [9:0]  region_limit,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);

	// Table geometry. Each RAM word packs base, size, free mark and owner.
	localparam int unsigned IW = $clog2(MAX_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned AW = $clog2(MEM_SIZE);
	localparam int unsigned SW = $clog2(MEM_SIZE + 1);
	localparam int unsigned XW = (SW > 11) ? SW : 11;
	localparam int unsigned OW = cfa_pkg::OWNER_W;
	localparam int unsigned EW = AW + SW + 1 + OW;
	localparam int unsigned FB = OW;
	localparam int unsigned SL = OW + 1;
	localparam int unsigned BL = OW + 1 + SW;

	typedef enum logic [3:0] {
		S_IDLE, S_MOD, S_SCAN, S_DECIDE, S_SPLIT_SHIFT, S_SPLIT_WR,
		S_USED_WR, S_FREE_NEXT, S_FREE_SHIFT, S_RESP
	} state_t;

	state_t state_q;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] pos_q;
	logic [OW-1:0] ctr_q;
	logic          conf_q;
	logic [1:0]    policy_q;
	logic [1:0]    req_q;
	logic [10:0]   size_q;
	logic [OW-1:0] owner_q;

	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] steps_q;
	logic          chk_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q;
	logic [IW-1:0] pick_q;
	logic [EW-1:0] pick_ent_q;
	logic [EW-1:0] prev_q;
	logic          split_q;
	logic [CW-1:0] sh_q;
	logic          wv_s1;
	logic [IW-1:0] wa_s1;
	logic [1:0]    rem_q;

	logic [2:0]    r_status_q;
	logic [OW-1:0] r_owner_q;
	logic [9:0]    r_base_q;
	logic [9:0]    r_limit_q;
	logic          out_valid_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	cfa_ram #(.W(EW), .D(MAX_ENTRIES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The policy is written only while no request is in progress. A pending
	// configuration transaction goes ahead of a request offered in the same cycle.
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;

	logic in_fire;
	assign in_fire = in_valid && in_ready;

	// Fields of the entry arriving from the RAM.
	logic          e_free;
	logic [SW-1:0] e_size;
	logic [OW-1:0] e_owner;
	assign e_free  = ram_rdata[FB];
	assign e_size  = ram_rdata[BL-1:SL];
	assign e_owner = ram_rdata[OW-1:0];

	logic [SW-1:0] p_size;
	logic [AW-1:0] p_base;
	assign p_size = pick_ent_q[BL-1:SL];
	assign p_base = pick_ent_q[EW-1:BL];

	logic [SW-1:0] req_size;
	assign req_size = XW'(size_q) > XW'(MEM_SIZE) ? SW'(0) : SW'(size_q);

	logic fit_hit, better, owner_hit, issue;
	assign fit_hit   = e_free && (XW'(e_size) >= XW'(size_q));
	assign owner_hit = !e_free && (e_owner == owner_q);
	assign better    = !found_q
		|| (policy_q == cfa_pkg::FIT_BEST  && e_size < p_size)
		|| (policy_q == cfa_pkg::FIT_WORST && e_size > p_size);
	assign issue     = steps_q < cnt_q;

	logic [IW-1:0] rd_ptr_next;
	assign rd_ptr_next = (CW'(rd_ptr_q) + CW'(1) == cnt_q) ? '0 : IW'(rd_ptr_q + 1'b1);

	// Coalescing of a released region with its free neighbors.
	logic          pf, nf, nxt_ok;
	logic [IW-1:0] dst;
	logic [AW-1:0] m_base;
	logic [SW-1:0] m_size;
	logic [1:0]    rem;
	assign nxt_ok = (CW'(pick_q) + CW'(1)) < cnt_q;
	assign pf     = (pick_q != '0) && prev_q[FB];
	assign nf     = nxt_ok && e_free;
	assign dst    = pf ? IW'(pick_q - 1'b1) : pick_q;
	assign m_base = pf ? prev_q[EW-1:BL] : p_base;
	assign m_size = (pf ? prev_q[BL-1:SL] : SW'(0)) + p_size + (nf ? e_size : SW'(0));
	assign rem    = 2'(pf) + 2'(nf);

	logic [CW-1:0] sh_dst;
	assign sh_dst = sh_q - CW'(rem_q);

	logic [31:0] lim_full;
	assign lim_full = 32'(p_base) + 32'(size_q) - 32'd1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = rd_ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && req_type == cfa_pkg::REQ_INIT && !conf_q) begin
					ram_we    = 1'b1;
					ram_wdata = {AW'(0), SW'(MEM_SIZE), 1'b1, OW'(0)};
				end
			end
			S_SPLIT_SHIFT, S_FREE_SHIFT: begin
				ram_raddr = sh_q[IW-1:0];
				ram_we    = wv_s1;
				ram_waddr = wa_s1;
				ram_wdata = ram_rdata;
			end
			S_SPLIT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = IW'(pick_q + 1'b1);
				ram_wdata = {AW'(p_base + AW'(req_size)), SW'(p_size - req_size), 1'b1, OW'(0)};
			end
			S_USED_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pick_q;
				ram_wdata = {p_base, req_size, 1'b0, ctr_q};
			end
			S_FREE_NEXT: begin
				ram_we    = 1'b1;
				ram_waddr = dst;
				ram_wdata = {m_base, m_size, 1'b1, OW'(0)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			ctr_q       <= '0;
			conf_q      <= 1'b0;
			policy_q    <= cfa_pkg::FIT_FIRST;
			chk_s1      <= 1'b0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				policy_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						req_q     <= req_type;
						size_q    <= request_size;
						owner_q   <= owner_id;
						r_status_q <= cfa_pkg::ST_OK;
						r_owner_q <= '0;
						r_base_q  <= '0;
						r_limit_q <= '0;
						rd_ptr_q  <= '0;
						steps_q   <= '0;
						chk_s1    <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= S_RESP;
						unique case (req_type)
							cfa_pkg::REQ_INIT: begin
								if (conf_q) begin
									r_status_q <= cfa_pkg::ST_ALREADY;
								end else begin
									cnt_q  <= CW'(1);
									ctr_q  <= '0;
									conf_q <= 1'b1;
								end
							end
							cfa_pkg::REQ_ALLOC: begin
								if (!conf_q) begin
									r_status_q <= cfa_pkg::ST_NOT_CONFIGURED;
								end else if (request_size == '0
										|| XW'(request_size) > XW'(MEM_SIZE)) begin
									r_status_q <= cfa_pkg::ST_BAD_SIZE;
								end else begin
									ctr_q     <= ctr_q + 1'b1;
									r_owner_q <= ctr_q + 1'b1;
									if (policy_q == cfa_pkg::FIT_NEXT) begin
										rd_ptr_q <= pos_q;
										state_q  <= S_MOD;
									end else begin
										state_q  <= S_SCAN;
									end
								end
							end
							cfa_pkg::REQ_FREE: begin
								if (!conf_q) begin
									r_status_q <= cfa_pkg::ST_NOT_CONFIGURED;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								cnt_q      <= '0;
								ctr_q      <= '0;
								conf_q     <= 1'b0;
								r_status_q <= cfa_pkg::ST_DONE;
							end
						endcase
					end
				end
				S_MOD: begin
					// Reduce the circular start position below the current entry count.
					if (CW'(rd_ptr_q) >= cnt_q) begin
						rd_ptr_q <= IW'(CW'(rd_ptr_q) - cnt_q);
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					chk_s1 <= issue;
					idx_s1 <= rd_ptr_q;
					if (issue) begin
						rd_ptr_q <= rd_ptr_next;
						steps_q  <= steps_q + 1'b1;
					end
					if (chk_s1) begin
						if (req_q == cfa_pkg::REQ_ALLOC) begin
							if (fit_hit && better) begin
								found_q    <= 1'b1;
								pick_q     <= idx_s1;
								pick_ent_q <= ram_rdata;
								if (policy_q == cfa_pkg::FIT_FIRST
										|| policy_q == cfa_pkg::FIT_NEXT) begin
									chk_s1  <= 1'b0;
									state_q <= S_DECIDE;
								end
							end
						end else begin
							if (owner_hit) begin
								pick_q     <= idx_s1;
								pick_ent_q <= ram_rdata;
								chk_s1     <= 1'b0;
								state_q    <= S_FREE_NEXT;
							end else begin
								prev_q <= ram_rdata;
							end
						end
					end else if (!issue) begin
						if (req_q == cfa_pkg::REQ_ALLOC) begin
							state_q <= S_DECIDE;
						end else begin
							r_status_q <= cfa_pkg::ST_NOT_ALLOCATED;
							state_q    <= S_RESP;
						end
					end
				end
				S_DECIDE: begin
					if (!found_q) begin
						r_status_q <= cfa_pkg::ST_NO_FIT;
						state_q    <= S_RESP;
					end else begin
						if (policy_q == cfa_pkg::FIT_NEXT) begin
							pos_q <= pick_q;
						end
						split_q <= p_size > req_size;
						if (p_size > req_size) begin
							if (cnt_q == CW'(MAX_ENTRIES)) begin
								r_status_q <= cfa_pkg::ST_TABLE_FULL;
								state_q    <= S_RESP;
							end else begin
								sh_q    <= cnt_q - 1'b1;
								wv_s1   <= 1'b0;
								state_q <= S_SPLIT_SHIFT;
							end
						end else begin
							state_q <= S_USED_WR;
						end
					end
				end
				S_SPLIT_SHIFT: begin
					// Move the tail up by one, top entry first.
					if (sh_q > CW'(pick_q)) begin
						wv_s1 <= 1'b1;
						wa_s1 <= IW'(sh_q + 1'b1);
						sh_q  <= sh_q - 1'b1;
					end else begin
						wv_s1 <= 1'b0;
						if (!wv_s1) begin
							state_q <= S_SPLIT_WR;
						end
					end
				end
				S_SPLIT_WR: begin
					state_q <= S_USED_WR;
				end
				S_USED_WR: begin
					if (split_q) begin
						cnt_q <= cnt_q + 1'b1;
					end
					r_base_q  <= 10'(p_base);
					r_limit_q <= lim_full[9:0];
					state_q   <= S_RESP;
				end
				S_FREE_NEXT: begin
					rem_q <= rem;
					if (rem == 2'd0) begin
						state_q <= S_RESP;
					end else begin
						sh_q    <= CW'(dst) + CW'(1) + CW'(rem);
						wv_s1   <= 1'b0;
						state_q <= S_FREE_SHIFT;
					end
				end
				S_FREE_SHIFT: begin
					// Close the gap left by the merged neighbors, lowest entry first.
					if (sh_q < cnt_q) begin
						wv_s1 <= 1'b1;
						wa_s1 <= sh_dst[IW-1:0];
						sh_q  <= sh_q + 1'b1;
					end else begin
						wv_s1 <= 1'b0;
						if (!wv_s1) begin
							cnt_q   <= cnt_q - CW'(rem_q);
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The output register is loaded only from the response state.
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			status         <= r_status_q;
			assigned_owner <= r_owner_q;
			region_base    <= r_base_q;
			region_limit   <= r_limit_q;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_conf_count, conf_q == (cnt_q != '0))
	`ASSERT_NEVER(a_count_range, cnt_q > CW'(MAX_ENTRIES))
	`ASSERT_CLK(a_out_hold, out_valid_q && !out_ready |=> out_valid_q)
	`ASSERT_NEVER(a_accept_busy, in_fire && state_q != S_IDLE)

endmodule

// ===== hw/rtl/cfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module cfa_ram #(
	parameter int unsigned W = 8,
	parameter int unsigned D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
